[rtl/kmst_pkg.sv]
// ----------------------------------------------------------------------------
// kmst_pkg
// shared types and constants for the kruskal spanning tree block
// ----------------------------------------------------------------------------
package kmst_pkg;

  localparam int NUM_VERTICES_DEF = 16;
  localparam int MAX_EDGES_DEF    = 64;
  localparam int VW               = 4;
  localparam int WW               = 16;
  localparam int CW               = 24;
  localparam int EW               = 2 * VW + WW;

  typedef struct packed {
    logic [VW-1:0]        from_v;
    logic [VW-1:0]        to_v;
    logic signed [WW-1:0] weight;
    logic                 last;
  } edge_t;

  typedef struct packed {
    logic [VW-1:0]        from_v;
    logic [VW-1:0]        to_v;
    logic signed [WW-1:0] weight;
    logic                 taken;
    logic signed [CW-1:0] cost;
    logic                 dropped;
    logic                 last;
  } res_t;

  typedef enum logic [3:0] {
    S_LOAD, S_SORT_RD, S_SORT_KEY, S_SORT_CMP, S_INIT, S_EDGE_RD, S_EDGE_LATCH,
    S_FIND_START, S_CLIMB, S_COMPRESS, S_JOIN, S_FLUSH
  } state_t;

endpackage

[rtl/kmst_fifo.sv]
// ----------------------------------------------------------------------------
// kmst_fifo
// short queue of accepted edges between the input side and the engine
// ----------------------------------------------------------------------------
module kmst_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  kmst_pkg::edge_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output kmst_pkg::edge_t rd_data
);
  kmst_pkg::edge_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign wr_ready = cnt_r != 3'd4;
  assign rd_valid = cnt_r != 3'd0;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= wp_r + 2'd1;
      if (rd_valid && rd_ready) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(wr_valid && wr_ready) - 3'(rd_valid && rd_ready);
    end
  end
endmodule

[rtl/kmst_engine.sv]
// ----------------------------------------------------------------------------
// kmst_engine
// stores edges, insertion sorts them, runs union-find and emits tree edges
// ----------------------------------------------------------------------------
module kmst_engine #(
  parameter int NUM_VERTICES = kmst_pkg::NUM_VERTICES_DEF,
  parameter int MAX_EDGES    = kmst_pkg::MAX_EDGES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            e_valid,
  output logic            e_ready,
  input  kmst_pkg::edge_t e_data,
  output logic            r_valid,
  input  logic            r_ready,
  output kmst_pkg::res_t  r_data
);
  localparam int AW  = $clog2(MAX_EDGES);
  localparam int CNW = $clog2(MAX_EDGES + 1);
  localparam int PW  = $clog2(NUM_VERTICES);
  localparam int EW  = kmst_pkg::EW;
  localparam int VW  = kmst_pkg::VW;
  localparam int WW  = kmst_pkg::WW;
  localparam int CW  = kmst_pkg::CW;
  localparam logic [31:0] NV_U = NUM_VERTICES;

  // edge memory, one write and one registered read port
  logic [EW-1:0] mem [MAX_EDGES];
  logic [EW-1:0] rdata_r;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  logic [PW-1:0] par_r  [NUM_VERTICES];
  logic [2:0]    rank_r [NUM_VERTICES];

  kmst_pkg::state_t     st_r, st_nxt;
  logic [CNW-1:0]       cnt_r, i_r;
  logic [AW-1:0]        j_r;
  logic [EW-1:0]        key_r, cur_r;
  logic                 ovf_r;
  logic signed [CW-1:0] cost_r;
  logic [PW-1:0]        x_r, root_r, rf_r;
  logic                 side_r;
  logic [PW:0]          ntaken_r;
  logic                 rv_r, rv_nxt;
  kmst_pkg::res_t       rd_r, out_nxt;
  kmst_pkg::res_t       pend_r, new_res;
  logic                 pend_v_r;
  logic                 out_load, join_go, shift, in_range, more_edges;
  logic [VW-1:0]        cf, ct;
  logic [PW-1:0]        vsel;
  logic signed [CW-1:0] cost_sum;

  function automatic logic signed [WW-1:0] wt(input logic [EW-1:0] e);
    return e[EW-1:2*VW];
  endfunction

  assign r_valid = rv_r;
  assign r_data  = rd_r;

  assign cf       = cur_r[VW-1:0];
  assign ct       = cur_r[2*VW-1:VW];
  assign vsel     = side_r ? PW'(ct) : PW'(cf);
  assign in_range = (32'(cf) < NV_U) && (32'(ct) < NV_U);
  assign cost_sum = cost_r + CW'(wt(cur_r));

  assign more_edges = (i_r < cnt_r) && (ntaken_r < (PW+1)'(NUM_VERTICES - 1));
  // neighbor below the hole is heavier than the key: move it up
  assign shift      = (j_r != '0) && (wt(rdata_r) > wt(key_r));
  // a held result can only move on once the output register is free
  assign join_go    = !(pend_v_r && rv_r);
  assign out_load   = ((st_r == kmst_pkg::S_JOIN) && pend_v_r && !rv_r) ||
                      ((st_r == kmst_pkg::S_FLUSH) && !rv_r);
  assign rv_nxt     = out_load || (rv_r && !r_ready);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      kmst_pkg::S_LOAD:
        if (e_valid && e_data.last) st_nxt = kmst_pkg::S_SORT_RD;
      kmst_pkg::S_SORT_RD:
        st_nxt = (i_r >= cnt_r) ? kmst_pkg::S_INIT : kmst_pkg::S_SORT_KEY;
      kmst_pkg::S_SORT_KEY:   st_nxt = kmst_pkg::S_SORT_CMP;
      kmst_pkg::S_SORT_CMP:
        if (!shift) st_nxt = kmst_pkg::S_SORT_RD;
      kmst_pkg::S_INIT:       st_nxt = kmst_pkg::S_EDGE_RD;
      kmst_pkg::S_EDGE_RD:
        st_nxt = more_edges ? kmst_pkg::S_EDGE_LATCH : kmst_pkg::S_FLUSH;
      kmst_pkg::S_EDGE_LATCH: st_nxt = kmst_pkg::S_FIND_START;
      kmst_pkg::S_FIND_START:
        st_nxt = in_range ? kmst_pkg::S_CLIMB : kmst_pkg::S_EDGE_RD;
      kmst_pkg::S_CLIMB:
        if (par_r[root_r] == root_r) st_nxt = kmst_pkg::S_COMPRESS;
      kmst_pkg::S_COMPRESS:
        if (par_r[x_r] == root_r) begin
          if (!side_r) st_nxt = kmst_pkg::S_FIND_START;
          else if (rf_r == root_r) st_nxt = kmst_pkg::S_EDGE_RD;
          else st_nxt = kmst_pkg::S_JOIN;
        end
      kmst_pkg::S_JOIN:
        if (join_go) st_nxt = kmst_pkg::S_EDGE_RD;
      kmst_pkg::S_FLUSH:
        if (!rv_r) st_nxt = kmst_pkg::S_LOAD;
      default:                st_nxt = kmst_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    e_ready = (st_r == kmst_pkg::S_LOAD);
    we      = 1'b0;
    waddr   = cnt_r[AW-1:0];
    wdata   = {e_data.weight, e_data.to_v, e_data.from_v};
    raddr   = '0;
    unique case (st_r)
      kmst_pkg::S_LOAD:     we = e_valid && (cnt_r < CNW'(MAX_EDGES));
      kmst_pkg::S_SORT_RD:  raddr = i_r[AW-1:0];
      kmst_pkg::S_SORT_KEY: raddr = i_r[AW-1:0] - AW'(1);
      kmst_pkg::S_SORT_CMP: begin
        we    = 1'b1;
        waddr = j_r;
        if (shift) begin
          wdata = rdata_r;
          raddr = (j_r >= AW'(2)) ? j_r - AW'(2) : '0;
        end else begin
          wdata = key_r;
        end
      end
      kmst_pkg::S_EDGE_RD:  raddr = i_r[AW-1:0];
      default: ;
    endcase
  end

  always_comb begin
    new_res         = '0;
    new_res.from_v  = cf;
    new_res.to_v    = ct;
    new_res.weight  = wt(cur_r);
    new_res.taken   = 1'b1;
    new_res.cost    = cost_sum;
    new_res.dropped = ovf_r;
    out_nxt         = pend_r;
    if (st_r == kmst_pkg::S_FLUSH) begin
      if (pend_v_r) begin
        out_nxt.last = 1'b1;
      end else begin
        out_nxt         = '0;
        out_nxt.dropped = ovf_r;
        out_nxt.last    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) rd_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= kmst_pkg::S_LOAD;
      cnt_r <= '0; ovf_r <= 1'b0; rv_r <= 1'b0; i_r <= '0; ntaken_r <= '0;
      pend_v_r <= 1'b0; side_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      rv_r <= rv_nxt;
      unique case (st_r)
        kmst_pkg::S_LOAD: if (e_valid) begin
          if (cnt_r < CNW'(MAX_EDGES)) cnt_r <= cnt_r + CNW'(1);
          else ovf_r <= 1'b1;
          if (e_data.last) i_r <= CNW'(1);
        end
        kmst_pkg::S_SORT_KEY: begin
          key_r <= rdata_r;
          j_r   <= i_r[AW-1:0];
        end
        kmst_pkg::S_SORT_CMP: begin
          if (shift) j_r <= j_r - AW'(1);
          else i_r <= i_r + CNW'(1);
        end
        kmst_pkg::S_INIT: begin
          for (int k = 0; k < NUM_VERTICES; k++) begin
            par_r[k] <= PW'(k); rank_r[k] <= '0;
          end
          i_r <= '0; ntaken_r <= '0; cost_r <= '0;
        end
        kmst_pkg::S_EDGE_LATCH: begin
          cur_r  <= rdata_r;
          i_r    <= i_r + CNW'(1);
          side_r <= 1'b0;
        end
        kmst_pkg::S_FIND_START: begin
          x_r    <= vsel;
          root_r <= vsel;
        end
        kmst_pkg::S_CLIMB:
          if (par_r[root_r] != root_r) root_r <= par_r[root_r];
        kmst_pkg::S_COMPRESS: begin
          if (par_r[x_r] != root_r) begin
            par_r[x_r] <= root_r; x_r <= par_r[x_r];
          end else if (!side_r) begin
            rf_r <= root_r; side_r <= 1'b1;
          end
        end
        kmst_pkg::S_JOIN: if (join_go) begin
          // hold the new tree edge until it is known whether it is the final one
          pend_r   <= new_res;
          pend_v_r <= 1'b1;
          cost_r   <= cost_sum;
          ntaken_r <= ntaken_r + (PW+1)'(1);
          if (rank_r[rf_r] < rank_r[root_r]) par_r[rf_r] <= root_r;
          else if (rank_r[root_r] < rank_r[rf_r]) par_r[root_r] <= rf_r;
          else begin
            par_r[root_r] <= rf_r;
            if (rank_r[rf_r] != 3'd7) rank_r[rf_r] <= rank_r[rf_r] + 3'd1;
          end
        end
        kmst_pkg::S_FLUSH: if (!rv_r) begin
          pend_v_r <= 1'b0;
          cnt_r <= '0; ovf_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule

[rtl/kruskal_mst_union_find.sv]
// ----------------------------------------------------------------------------
// kruskal_mst_union_find
// minimum spanning tree by kruskal's method over a union-find store
// ----------------------------------------------------------------------------
// operation: edges load one per cycle while the engine is in its load state;
//   after the last edge an insertion sort orders the stored edges by weight,
//   then each edge takes find walks with path compression on both ends, one
//   tree edge held back until the next is known
// throughput: one graph at a time, next graph's edges wait in a 4-deep queue
// reset: rst_n synchronous active low clears the control state and counts
module kruskal_mst_union_find #(
  parameter int NUM_VERTICES = kmst_pkg::NUM_VERTICES_DEF,
  parameter int MAX_EDGES    = kmst_pkg::MAX_EDGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // edge_from, edge_to, edge_weight
  input  logic        in_tlast,   // last_edge
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // tree_from, tree_to, tree_weight, running_cost
  output logic [1:0]  out_tuser,  // edge_taken, dropped_edges
  output logic        out_tlast   // last_result
);
  kmst_pkg::edge_t in_e, q_e;
  logic q_valid, q_ready;
  kmst_pkg::res_t r;

  // unpack one edge transfer
  assign in_e.from_v = in_tdata[3:0];
  assign in_e.to_v   = in_tdata[7:4];
  assign in_e.weight = in_tdata[23:8];
  assign in_e.last   = in_tlast;

  // front: 4-entry edge queue, takes edges while the engine works until it is full
  kmst_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(in_tvalid), .wr_ready(in_tready), .wr_data(in_e),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_e)
  );

  // back: store, sort, union-find; result register drives the output side
  kmst_engine #(.NUM_VERTICES(NUM_VERTICES), .MAX_EDGES(MAX_EDGES)) u_eng (
    .clk, .rst_n,
    .e_valid(q_valid), .e_ready(q_ready), .e_data(q_e),
    .r_valid(out_tvalid), .r_ready(out_tready), .r_data(r)
  );

  // pack the result transfer, first field in the lowest bits
  assign out_tdata = {r.cost, r.weight, r.to_v, r.from_v};
  assign out_tuser = {r.dropped, r.taken};
  assign out_tlast = r.last;
endmodule

[rtl/kmst_checker.sv]
// ----------------------------------------------------------------------------
// kmst_checker
// port-level checks of the spanning tree block
// ----------------------------------------------------------------------------
module kmst_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast)) else $error("result dropped");
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && out_tdata == '0)
    else $error("bad empty result");
  a_loop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[3:0] != out_tdata[7:4])
    else $error("self loop taken");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("valid after reset");
endmodule

bind kruskal_mst_union_find kmst_checker u_chk (.*);

[verif/kruskal_mst_union_find_checker.sv]
// ----------------------------------------------------------------------------
// kruskal_mst_union_find_checker
// watches edge and tree transfers, predicts the spanning tree, compares
// ----------------------------------------------------------------------------
module kruskal_mst_union_find_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          tree_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV   = kmst_pkg::NUM_VERTICES_DEF;
  localparam int MAXE = kmst_pkg::MAX_EDGES_DEF;
  localparam int VW   = kmst_pkg::VW;
  localparam int WW   = kmst_pkg::WW;
  localparam int CW   = kmst_pkg::CW;

  logic [VW-1:0]        graph_from [MAXE];
  logic [VW-1:0]        graph_to   [MAXE];
  logic signed [WW-1:0] graph_wt   [MAXE];
  int                   graph_edges;
  logic                 graph_overflow;
  logic [VW-1:0]        uf_parent  [NV];
  logic [2:0]           uf_rank    [NV];
  kmst_pkg::res_t       tree_queue [$];

  function automatic int root_of(int x);
    int r;
    int n;
    int nx;
    r = x;
    n = 0;
    while (uf_parent[r] != r && n < NV) begin
      r = uf_parent[r];
      n++;
    end
    n = 0;
    while (uf_parent[x] != r && n < NV) begin
      nx = uf_parent[x];
      uf_parent[x] = VW'(r);
      x = nx;
      n++;
    end
    return r;
  endfunction

  // sort, run kruskal, queue one tree edge per join or an empty result
  task automatic build_tree();
    logic [VW-1:0]        kf;
    logic [VW-1:0]        kt;
    logic signed [WW-1:0] kw;
    int                   j;
    int                   ra;
    int                   rb;
    int                   taken;
    logic signed [CW-1:0] cost;
    kmst_pkg::res_t       r;
    for (int i = 1; i < graph_edges; i++) begin
      kf = graph_from[i];
      kt = graph_to[i];
      kw = graph_wt[i];
      j = i;
      while (j > 0 && graph_wt[j-1] > kw) begin
        graph_from[j] = graph_from[j-1];
        graph_to[j]   = graph_to[j-1];
        graph_wt[j]   = graph_wt[j-1];
        j--;
      end
      graph_from[j] = kf;
      graph_to[j]   = kt;
      graph_wt[j]   = kw;
    end
    for (int i = 0; i < NV; i++) begin
      uf_parent[i] = VW'(i);
      uf_rank[i]   = 3'd0;
    end
    taken = 0;
    cost  = '0;
    for (int i = 0; i < graph_edges && taken < NV - 1; i++) begin
      ra = root_of(graph_from[i]);
      rb = root_of(graph_to[i]);
      if (ra == rb) continue;
      cost += graph_wt[i];
      r = '0;
      r.from_v  = graph_from[i];
      r.to_v    = graph_to[i];
      r.weight  = graph_wt[i];
      r.taken   = 1'b1;
      r.cost    = cost;
      r.dropped = graph_overflow;
      tree_queue.insert(tree_queue.size(), r);
      taken++;
      if (uf_rank[ra] < uf_rank[rb]) begin
        uf_parent[ra] = VW'(rb);
      end else if (uf_rank[rb] < uf_rank[ra]) begin
        uf_parent[rb] = VW'(ra);
      end else begin
        uf_parent[rb] = VW'(ra);
        if (uf_rank[ra] < 3'd7) uf_rank[ra]++;
      end
    end
    if (taken == 0) begin
      r = '0;
      r.dropped = graph_overflow;
      tree_queue.insert(tree_queue.size(), r);
    end
    r = tree_queue[tree_queue.size() - 1];
    r.last = 1'b1;
    tree_queue[tree_queue.size() - 1] = r;
    graph_edges    = 0;
    graph_overflow = 1'b0;
  endtask

  task automatic compare_tree_edge();
    kmst_pkg::res_t e;
    if (tree_queue.size() == 0) begin
      $error("unexpected result transfer tdata=%h tuser=%b", out_tdata, out_tuser);
      fail_count++;
      return;
    end
    e = tree_queue.pop_front();
    if (out_tdata[3:0] !== e.from_v) begin
      $error("tree_from exp %0d got %0d", e.from_v, out_tdata[3:0]); fail_count++;
    end
    if (out_tdata[7:4] !== e.to_v) begin
      $error("tree_to exp %0d got %0d", e.to_v, out_tdata[7:4]); fail_count++;
    end
    if (out_tdata[23:8] !== e.weight) begin
      $error("tree_weight exp %0d got %0d", e.weight, $signed(out_tdata[23:8]));
      fail_count++;
    end
    if (out_tdata[47:24] !== e.cost) begin
      $error("running_cost exp %0d got %0d", e.cost, $signed(out_tdata[47:24]));
      fail_count++;
    end
    if (out_tuser[0] !== e.taken) begin
      $error("edge_taken exp %0b got %0b", e.taken, out_tuser[0]); fail_count++;
    end
    if (out_tuser[1] !== e.dropped) begin
      $error("dropped_edges exp %0b got %0b", e.dropped, out_tuser[1]); fail_count++;
    end
    if (out_tlast !== e.last) begin
      $error("last_result exp %0b got %0b", e.last, out_tlast); fail_count++;
    end
  endtask

  initial begin
    fail_count     = 0;
    tree_pending   = 0;
    graph_edges    = 0;
    graph_overflow = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) compare_tree_edge();
      if (in_tvalid && in_tready) begin
        if (graph_edges < MAXE) begin
          graph_from[graph_edges] = in_tdata[3:0];
          graph_to[graph_edges]   = in_tdata[7:4];
          graph_wt[graph_edges]   = in_tdata[23:8];
          graph_edges++;
        end else begin
          graph_overflow = 1'b1;
        end
        if (in_tlast) build_tree();
      end
      tree_pending = tree_queue.size();
    end
  end

endmodule

[verif/kruskal_mst_union_find_tb.sv]
// ----------------------------------------------------------------------------
// kruskal_mst_union_find_tb
// drives graphs of weighted edges into the spanning tree block under varied
// backpressure; a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module kruskal_mst_union_find_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // edge_from, edge_to, edge_weight
  logic        in_tlast;   // last_edge
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // tree_from, tree_to, tree_weight, running_cost
  logic [1:0]  out_tuser;  // edge_taken, dropped_edges
  logic        out_tlast;  // last_result
  int          fail_count;
  int          tree_pending;
  int          send_idle_pct;   // chance per cycle the sender holds off
  int          recv_stall_pct;  // chance per cycle the receiver stalls
  int          quiet_cycles;

  kruskal_mst_union_find u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  kruskal_mst_union_find_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .fail_count(fail_count), .tree_pending(tree_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver stalls at random, changing on the falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: ends the run after too many cycles with no transfer at all
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // one edge transfer, with random hold-off before it
  task automatic send_edge(input logic [3:0] f, input logic [3:0] t,
                           input logic [15:0] w, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {w, t, f};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // random graph over vertices 0 to vmax; mostly small weights, some wide ones
  task automatic send_graph(input int n_edges, input int vmax);
    logic [15:0] w;
    for (int i = 0; i < n_edges; i++) begin
      case ($urandom_range(3))
        0: w = 16'($urandom);
        1: w = 16'($urandom_range(7));
        default: w = 16'($urandom_range(40)) - 16'd20;
      endcase
      send_edge(4'($urandom_range(vmax)), 4'($urandom_range(vmax)), w,
                i == n_edges - 1);
    end
  endtask

  // stop sending and wait until every predicted result has been seen
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (tree_pending != 0) @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // single edge, extreme weights
    send_edge(4'd0, 4'd15, 16'h7fff, 1'b1);
    send_edge(4'd15, 4'd0, 16'h8000, 1'b1);
    // lone self loop gives the empty result
    send_edge(4'd5, 4'd5, 16'd3, 1'b1);
    // equal weights keep arrival order, cycle rejected, self loop skipped
    send_edge(4'd1, 4'd2, 16'd4, 1'b0);
    send_edge(4'd2, 4'd3, 16'd4, 1'b0);
    send_edge(4'd3, 4'd1, 16'd4, 1'b0);
    send_edge(4'd7, 4'd7, 16'hffff, 1'b0);
    send_edge(4'd3, 4'd4, 16'hfffe, 1'b1);
    // full chain across all vertices, descending weights so the sort works
    for (int i = 0; i < 15; i++)
      send_edge(4'(i), 4'(i + 1), 16'(100 - i * 13), i == 14);
    wait_drained();

    // overflow: more edges than the store holds, last mark on a dropped edge
    send_graph(70, 15);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (int g = 0; g < 5; g++) begin
        // mostly small graphs, now and then a dense or a sparse one
        case ($urandom_range(7))
          0: send_graph($urandom_range(40, 64), 15);
          1: send_graph($urandom_range(1, 4), 15);
          2: send_graph($urandom_range(4, 12), 3);
          default: send_graph($urandom_range(5, 16), 15);
        endcase
      end
      wait_drained();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    // a quiet tail catches any stray result
    repeat (100) @(posedge clk);
    if (fail_count == 0 && tree_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
